/* sv/mwdd_pkg.sv */
package mwdd_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int COST_W  = 19;

    typedef enum logic [1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_RUN           = 2'd2,
        CMD_NONE          = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN
    } state_t;

    // one beat travelling along the cell row: a byte of the second string and
    // the cost from the row above
    typedef struct packed {
        logic              v;
        logic              last;
        logic [7:0]        b;
        logic [COST_W-1:0] d;
    } beat_t;

    // per-cell load controls
    typedef struct packed {
        logic              load;
        logic              clear;
        logic [7:0]        ch;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
    } cell_ctl_t;

endpackage

/* sv/mwdd_ram.sv */
module mwdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/mwdd_cell.sv */
module mwdd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mwdd_pkg::cell_ctl_t ctl,
    input  mwdd_pkg::beat_t    bin,
    output mwdd_pkg::beat_t    bout
);

    logic                        active_reg;
    logic [7:0]                  a_reg;
    logic [mwdd_pkg::COST_W-1:0] left_reg;
    logic [mwdd_pkg::COST_W-1:0] diag_reg;
    mwdd_pkg::beat_t             bout_reg;
    mwdd_pkg::beat_t             bout_next;

    logic [mwdd_pkg::COST_W:0]   del_first;
    logic [mwdd_pkg::COST_W:0]   del_second;
    logic [mwdd_pkg::COST_W-1:0] val;

    always_comb
    begin
        del_first  = {1'b0, bin.d} + {{(mwdd_pkg::COST_W - 7){1'b0}}, a_reg};
        del_second = {1'b0, left_reg} + {{(mwdd_pkg::COST_W - 7){1'b0}}, bin.b};
        if (a_reg == bin.b)
        begin
            val = diag_reg;
        end
        else if (del_first < del_second)
        begin
            val = del_first[mwdd_pkg::COST_W-1:0];
        end
        else
        begin
            val = del_second[mwdd_pkg::COST_W-1:0];
        end

        bout_next      = bin;
        // idle cells past the end of the first string pass the beat on untouched
        bout_next.d    = active_reg ? val : bin.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bout_reg   <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                active_reg <= 1'b1;
            end
            else if (ctl.clear)
            begin
                active_reg <= 1'b0;
            end
            bout_reg <= bin.v ? bout_next : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg    <= ctl.ch;
            left_reg <= ctl.left;
            diag_reg <= ctl.diag;
        end
        else if (bin.v && active_reg)
        begin
            left_reg <= val;
            diag_reg <= bin.d;
        end
    end

    assign bout = bout_reg;

endmodule

/* sv/min_weighted_delete_distance.sv */
// Appends: one beat per cycle while no run is in progress, no result.
// Run: the second string is read from its RAM one byte a cycle and each byte walks the
// whole cell row; the result is registered when the last byte leaves the row.
// A run with an empty second string answers in the next cycle.
// Input is held off while a run is in progress; a further run waits until the previous result is taken.
// Reset (rst_n, asynchronous, active low) empties both strings and clears the flag.
module min_weighted_delete_distance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [18:0] cost,
    output logic        dropped
);

    localparam int N  = mwdd_pkg::MAX_LEN;
    localparam int AW = mwdd_pkg::ADDR_W;
    localparam int LW = mwdd_pkg::LEN_W;
    localparam int CW = mwdd_pkg::COST_W;

    mwdd_pkg::state_t state_reg, state_next;

    logic [LW-1:0] len_a_reg, len_b_reg;
    logic [CW-1:0] sum_a_reg, acc_reg;
    logic          ovf_reg;
    logic [LW-1:0] j_reg;
    logic          rd_v_reg, rd_last_reg;
    logic          out_valid_reg, dropped_reg;
    logic [CW-1:0] cost_reg;
    mwdd_pkg::beat_t src_reg;

    logic            accept;
    logic            ap_a, ap_b, run;
    logic            full_a, full_b;
    logic            feed_en, run_empty_b, finish;
    logic [7:0]      rd_data;
    logic [CW-1:0]   acc_sum;
    mwdd_pkg::beat_t chain [N+1];

    assign full_a = (len_a_reg == LW'(N));
    assign full_b = (len_b_reg == LW'(N));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwdd_pkg::S_IDLE:
            begin
                if (run && !run_empty_b)
                begin
                    state_next = mwdd_pkg::S_FEED;
                end
            end
            mwdd_pkg::S_FEED:
            begin
                if (j_reg == len_b_reg - LW'(1))
                begin
                    state_next = mwdd_pkg::S_DRAIN;
                end
            end
            mwdd_pkg::S_DRAIN:
            begin
                if (finish)
                begin
                    state_next = mwdd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mwdd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        feed_en  = 1'b0;
        unique case (state_reg)
            mwdd_pkg::S_IDLE:
            begin
                in_ready = (cmd != mwdd_pkg::CMD_RUN) || !out_valid_reg;
            end
            mwdd_pkg::S_FEED:
            begin
                feed_en = 1'b1;
            end
            mwdd_pkg::S_DRAIN:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept      = in_valid && in_ready;
    assign ap_a        = accept && (cmd == mwdd_pkg::CMD_APPEND_FIRST);
    assign ap_b        = accept && (cmd == mwdd_pkg::CMD_APPEND_SECOND);
    assign run         = accept && (cmd == mwdd_pkg::CMD_RUN);
    assign run_empty_b = (len_b_reg == '0);
    assign finish      = chain[N].v && chain[N].last;
    assign acc_sum     = acc_reg + CW'(rd_data);

    mwdd_ram #(
        .WIDTH (8),
        .DEPTH (N)
    ) u_second (
        .clk   (clk),
        .we    (ap_b && !full_b),
        .waddr (len_b_reg[AW-1:0]),
        .wdata (ch),
        .raddr (j_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign chain[0] = src_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        mwdd_pkg::cell_ctl_t ctl;
        always_comb
        begin
            ctl.load  = ap_a && !full_a && (len_a_reg[AW-1:0] == AW'(k));
            ctl.clear = finish || (run && run_empty_b);
            ctl.ch    = ch;
            ctl.left  = sum_a_reg + CW'(ch);
            ctl.diag  = sum_a_reg;
        end
        mwdd_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ctl),
            .bin  (chain[k]),
            .bout (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwdd_pkg::S_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            sum_a_reg     <= '0;
            ovf_reg       <= 1'b0;
            j_reg         <= '0;
            acc_reg       <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            src_reg       <= '0;
            out_valid_reg <= 1'b0;
            cost_reg      <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ap_a)
            begin
                if (full_a)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_a_reg <= len_a_reg + LW'(1);
                    sum_a_reg <= sum_a_reg + CW'(ch);
                end
            end

            if (ap_b)
            begin
                if (full_b)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_b_reg <= len_b_reg + LW'(1);
                end
            end

            if (run)
            begin
                j_reg   <= '0;
                acc_reg <= '0;
            end
            else if (feed_en)
            begin
                j_reg <= j_reg + LW'(1);
            end

            rd_v_reg    <= feed_en;
            rd_last_reg <= feed_en && (j_reg == len_b_reg - LW'(1));

            // first cell sees the top row: prefix sums of the second string
            if (rd_v_reg)
            begin
                acc_reg      <= acc_sum;
                src_reg.v    <= 1'b1;
                src_reg.last <= rd_last_reg;
                src_reg.b    <= rd_data;
                src_reg.d    <= acc_sum;
            end
            else
            begin
                src_reg <= '0;
            end

            if ((run && run_empty_b) || finish)
            begin
                out_valid_reg <= 1'b1;
                cost_reg      <= finish ? chain[N].d : sum_a_reg;
                dropped_reg   <= ovf_reg;
                len_a_reg     <= '0;
                len_b_reg     <= '0;
                sum_a_reg     <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cost      = cost_reg;
    assign dropped   = dropped_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    class delete_sum_board;
        byte unsigned first_q[$];
        byte unsigned second_q[$];
        bit           overflow;
        int unsigned  cost_q[$];
        bit           drop_q[$];
        int           errors;
        int           checked;

        function int unsigned min_delete_sum();
            int unsigned row[];
            int unsigned acc;
            int unsigned diag;
            int unsigned below;
            int unsigned val;
            int unsigned d1;
            int unsigned d2;
            int          n;
            int          m;
            n = first_q.size();
            m = second_q.size();
            row = new[m + 1];
            acc = 0;
            row[m] = 0;
            for (int j = m; j > 0; j--)
            begin
                acc += second_q[j - 1];
                row[j - 1] = acc;
            end
            acc = 0;
            for (int i = n; i > 0; i--)
            begin
                diag = row[m];
                acc += first_q[i - 1];
                row[m] = acc;
                for (int j = m; j > 0; j--)
                begin
                    below = row[j - 1];
                    if (first_q[i - 1] == second_q[j - 1])
                        val = diag;
                    else
                    begin
                        d1 = first_q[i - 1] + below;
                        d2 = second_q[j - 1] + row[j];
                        val = (d1 < d2) ? d1 : d2;
                    end
                    row[j - 1] = val;
                    diag = below;
                end
            end
            return (row[0] > 524287) ? 524287 : row[0];
        endfunction

        function void note_beat(logic [1:0] c, logic [7:0] b);
            case (mwdd_pkg::cmd_t'(c))
                mwdd_pkg::CMD_APPEND_FIRST:
                    if (first_q.size() < mwdd_pkg::MAX_LEN) first_q.push_back(b);
                    else overflow = 1;
                mwdd_pkg::CMD_APPEND_SECOND:
                    if (second_q.size() < mwdd_pkg::MAX_LEN) second_q.push_back(b);
                    else overflow = 1;
                mwdd_pkg::CMD_RUN:
                begin
                    cost_q.push_back(min_delete_sum());
                    drop_q.push_back(overflow);
                    first_q.delete();
                    second_q.delete();
                    overflow = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [18:0] c, logic d);
            int unsigned ec;
            bit          ed;
            if (cost_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result cost=%0d dropped=%0d", c, d);
                return;
            end
            ec = cost_q.pop_front();
            ed = drop_q.pop_front();
            checked++;
            if (c !== ec[18:0] || d !== ed)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: cost exp %0d got %0d, dropped exp %0d got %0d",
                             ec, c, ed, d);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [18:0] cost;
    logic        dropped;

    delete_sum_board board;
    int              idle_cycles;
    int              sent;
    bit              sink_stall;

    localparam int WATCHDOG = 20000;

    min_weighted_delete_distance u_dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays high across back-to-back beats; dropped only ahead of a gap
    task send_beat(input logic [1:0] c, input logic [7:0] b, input bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        ch       <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_beat(c, b);
        sent++;
    endtask

    task load_string(input mwdd_pkg::cmd_t c, input int len, input int style, input bit gaps);
        logic [7:0] b;
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'($urandom_range(97, 100));   // small alphabet, many matches
                2: b = 8'hFF;
                default: b = $urandom_range(0, 1) ? 8'h00 : 8'h80;
            endcase
            send_beat(c, b, gaps);
        end
    endtask

    // sink: random back-pressure, with calm stretches
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) board.check_result(cost, dropped);
            if (sink_stall) out_ready <= ($urandom_range(0, 3) == 0);
            else out_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0) sink_stall <= ~sink_stall;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired after %0d beats", sent);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int sel;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = mwdd_pkg::CMD_NONE;
        ch = 8'h00;
        out_ready = 1'b0;
        sink_stall = 1'b0;
        idle_cycles = 0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty run, one-sided, extremes, ignored command
        send_beat(mwdd_pkg::CMD_RUN, 8'hA5, 0);
        send_beat(mwdd_pkg::CMD_APPEND_FIRST, 8'hFF, 0);
        send_beat(mwdd_pkg::CMD_APPEND_FIRST, 8'h00, 0);
        send_beat(mwdd_pkg::CMD_RUN, 8'h00, 0);
        send_beat(mwdd_pkg::CMD_APPEND_SECOND, 8'h55, 0);
        send_beat(mwdd_pkg::CMD_APPEND_SECOND, 8'hAA, 0);
        send_beat(mwdd_pkg::CMD_RUN, 8'hFF, 0);
        send_beat(mwdd_pkg::CMD_APPEND_FIRST, 8'h41, 0);
        send_beat(mwdd_pkg::CMD_NONE, 8'h42, 0);
        send_beat(mwdd_pkg::CMD_APPEND_SECOND, 8'h41, 0);
        send_beat(mwdd_pkg::CMD_APPEND_FIRST, 8'h7F, 0);
        send_beat(mwdd_pkg::CMD_APPEND_SECOND, 8'h80, 0);
        send_beat(mwdd_pkg::CMD_RUN, 8'h00, 0);

        // full stores: worst cost and dropped appends
        load_string(mwdd_pkg::CMD_APPEND_FIRST, mwdd_pkg::MAX_LEN, 2, 0);
        load_string(mwdd_pkg::CMD_APPEND_SECOND, mwdd_pkg::MAX_LEN, 3, 0);
        send_beat(mwdd_pkg::CMD_APPEND_FIRST, 8'h12, 0);
        send_beat(mwdd_pkg::CMD_APPEND_SECOND, 8'h34, 0);
        send_beat(mwdd_pkg::CMD_RUN, 8'h00, 0);
        load_string(mwdd_pkg::CMD_APPEND_SECOND, mwdd_pkg::MAX_LEN + 1, 0, 0);
        send_beat(mwdd_pkg::CMD_RUN, 8'h00, 0);

        // random: mostly short well-formed pairs, some noise
        sent = 0;
        while (sent < 750)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                load_string(mwdd_pkg::CMD_APPEND_FIRST, $urandom_range(0, 12), sel % 4, 1);
                load_string(mwdd_pkg::CMD_APPEND_SECOND, $urandom_range(0, 12),
                            (sel + 1) % 4, 1);
                send_beat(mwdd_pkg::CMD_RUN, 8'($urandom_range(0, 255)), 1);
            end
            else
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1);
        end
        send_beat(mwdd_pkg::CMD_RUN, 8'h00, 1);
        in_valid <= 1'b0;

        while (board.cost_q.size() != 0) @(posedge clk);
        repeat (mwdd_pkg::MAX_LEN + 50) @(posedge clk);
        $display("ran %0d random beats after directed checks incl. full stores", sent);
        $display("%0d costs compared, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0 && board.cost_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
